// ===== sv/cfrc_pkg.sv =====
// Shared types, constants and the CRC byte update for the record frame checker.
// No dependencies; used by cfrc_result_queue and crc_framed_record_checker.
package cfrc_pkg;

  // CRC-32/ISO-HDLC, reflected form
  localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
  localparam logic [31:0] CRC_ONES  = 32'hFFFF_FFFF;

  // frame layout
  localparam logic [3:0]  MIN_FRAME = 4'd13;
  localparam logic [3:0]  POS_MAX   = 4'd15;
  localparam logic [3:0]  WIN_DEPTH = 4'd4;

  // status codes
  localparam logic [2:0]  ST_OK        = 3'd0;
  localparam logic [2:0]  ST_SHORT     = 3'd1;
  localparam logic [2:0]  ST_CRC_BAD   = 3'd2;
  localparam logic [2:0]  ST_MAGIC_BAD = 3'd3;
  localparam logic [2:0]  ST_VER_BAD   = 3'd4;

  // result kinds
  localparam logic        KIND_PAYLOAD = 1'b0;
  localparam logic        KIND_STATUS  = 1'b1;

  // register map (byte address bit 2 selects the register)
  localparam logic        REG_MAGIC   = 1'b0;
  localparam logic        REG_VERSION = 1'b1;

  // result queue sizing
  localparam int          QDEPTH = 4;
  localparam int          QPTR_W = 2;
  localparam int          QCNT_W = 3;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
  } in_req_t;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  payload_byte;
    logic [2:0]  check_status;
    logic [31:0] decoded_count;
    logic        run_last;
  } out_req_t;

  // results pushed for one accepted byte
  typedef struct packed {
    logic [1:0] num;
    out_req_t   first;
    out_req_t   second;
  } push_t;

  // one byte through the reflected CRC register
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== sv/cfrc_result_queue.sv =====
// Four-entry result queue that takes up to two results per cycle and hands
// out one. Depends on cfrc_pkg for the result struct and queue sizing.
module cfrc_result_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  cfrc_pkg::push_t   push,
  output logic              room,
  output logic              out_valid,
  input  logic              out_ready,
  output cfrc_pkg::out_req_t out_data
);

  cfrc_pkg::out_req_t                  q_r [cfrc_pkg::QDEPTH];
  logic [cfrc_pkg::QPTR_W-1:0]         wr_r, wr_nxt;
  logic [cfrc_pkg::QPTR_W-1:0]         rd_r, rd_nxt;
  logic [cfrc_pkg::QCNT_W-1:0]         cnt_r, cnt_nxt;
  logic [cfrc_pkg::QPTR_W-1:0]         wr_second;
  logic                                pop;

  // room for a worst-case pair of results
  assign room      = cnt_r <= cfrc_pkg::QCNT_W'(cfrc_pkg::QDEPTH - 2);
  assign out_valid = cnt_r != '0;
  assign out_data  = q_r[rd_r];
  assign pop       = out_valid & out_ready;
  assign wr_second = wr_r + cfrc_pkg::QPTR_W'(1);

  // pointer and fill bookkeeping
  always_comb begin
    wr_nxt  = wr_r + cfrc_pkg::QPTR_W'(push.num);
    rd_nxt  = rd_r + cfrc_pkg::QPTR_W'(pop);
    cnt_nxt = cnt_r + cfrc_pkg::QCNT_W'(push.num) - cfrc_pkg::QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push.num != 2'd0) begin
      q_r[wr_r] <= push.first;
    end
    if (push.num == 2'd2) begin
      q_r[wr_second] <= push.second;
    end
  end

endmodule

// ===== sv/crc_framed_record_checker.sv =====
// Record frame checker: header checks, CRC-32 trailer check, payload streaming.
// Depends on cfrc_pkg and cfrc_result_queue.
//
// Usage: frame bytes arrive on the in_ channel (valid/ready), one byte per
// request, with frame_end set on the last byte of a frame. Each byte first
// enters a four-byte delay window; when it leaves, it is folded into the CRC,
// checked as magic or version, gathered into the record count, or (offset 9
// and later) sent out as a payload result. On frame_end one status result
// follows: ok, too short, CRC mismatch, bad magic or bad version, with the
// record count. The frame state then returns to its reset values.
// A result is registered in the result queue when its byte is taken and is
// offered on out_ from there. Throughput: one byte per cycle while the queue
// has room, since the byte CRC update is combinational; at the end of a frame
// the status result is one more result for the output side. The four-entry
// queue sits between the two sides; in_ready drops only when fewer than two
// entries are free, so a stalled receiver backs up the input; nothing is lost.
// Reset (rst_n low, synchronous) clears the frame state and the queue and
// sets magic_word and format_version to zero. The APB port (psel, penable,
// pwrite, paddr, pwdata, prdata, pready) holds magic_word at 0x0 and
// format_version at 0x4; write it only while the block is idle.
module crc_framed_record_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  cfrc_pkg::in_req_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output cfrc_pkg::out_req_t out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // configuration registers
  logic [31:0] magic_r;
  logic [7:0]  version_r;

  // frame state
  logic [31:0] crc_r, crc_nxt;
  logic [7:0]  win_r [4];
  logic [7:0]  win_nxt [4];
  logic [3:0]  pos_r, pos_nxt;
  logic        magic_ok_r, magic_ok_nxt;
  logic        version_ok_r, version_ok_nxt;
  logic [31:0] count_r, count_nxt;

  logic        in_fire;
  logic        has_leave;
  logic [7:0]  leave;
  logic [3:0]  off;
  logic [1:0]  cnt_sel;
  logic [31:0] magic_sh;
  logic [31:0] crc_step;
  logic [31:0] stored;
  logic        is_pay;
  logic [2:0]  status;
  logic        room;
  cfrc_pkg::push_t    push;
  cfrc_pkg::out_req_t pay_res;
  cfrc_pkg::out_req_t st_res;

  assign pready   = 1'b1;
  assign in_ready = room;
  assign in_fire  = in_valid & in_ready;

  // register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r   <= '0;
      version_r <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        cfrc_pkg::REG_MAGIC:   magic_r   <= pwdata;
        cfrc_pkg::REG_VERSION: version_r <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      cfrc_pkg::REG_MAGIC:   prdata = magic_r;
      cfrc_pkg::REG_VERSION: prdata = {24'd0, version_r};
      default:               prdata = '0;
    endcase
  end

  // byte leaving the delay window
  assign has_leave = pos_r >= cfrc_pkg::WIN_DEPTH;
  assign leave     = win_r[0];
  assign off       = pos_r - cfrc_pkg::WIN_DEPTH;
  assign cnt_sel   = off[1:0] - 2'd1;
  assign magic_sh  = magic_r >> {off[1:0], 3'b000};
  assign crc_step  = cfrc_pkg::crc_byte(crc_r, leave);
  assign is_pay    = has_leave && (off >= 4'd9);

  // next frame state and status
  always_comb begin
    crc_nxt        = has_leave ? crc_step : crc_r;
    magic_ok_nxt   = magic_ok_r;
    version_ok_nxt = version_ok_r;
    count_nxt      = count_r;
    if (has_leave && off < 4'd4 && leave != magic_sh[7:0]) begin
      magic_ok_nxt = 1'b0;
    end
    if (has_leave && off == 4'd4 && leave != version_r) begin
      version_ok_nxt = 1'b0;
    end
    if (has_leave && off >= 4'd5 && off <= 4'd8) begin
      count_nxt = count_r | ({24'd0, leave} << {cnt_sel, 3'b000});
    end
    win_nxt[0] = win_r[1];
    win_nxt[1] = win_r[2];
    win_nxt[2] = win_r[3];
    win_nxt[3] = in_data.frame_byte;
    pos_nxt    = (pos_r == cfrc_pkg::POS_MAX) ? pos_r : pos_r + 4'd1;

    // trailer is the window after the shift, little-endian
    stored = {in_data.frame_byte, win_r[3], win_r[2], win_r[1]};
    if (pos_nxt < cfrc_pkg::MIN_FRAME) begin
      status = cfrc_pkg::ST_SHORT;
    end else if (stored != (crc_nxt ^ cfrc_pkg::CRC_ONES)) begin
      status = cfrc_pkg::ST_CRC_BAD;
    end else if (!magic_ok_nxt) begin
      status = cfrc_pkg::ST_MAGIC_BAD;
    end else if (!version_ok_nxt) begin
      status = cfrc_pkg::ST_VER_BAD;
    end else begin
      status = cfrc_pkg::ST_OK;
    end
  end

  // results for this byte
  always_comb begin
    pay_res.result_kind   = cfrc_pkg::KIND_PAYLOAD;
    pay_res.payload_byte  = leave;
    pay_res.check_status  = cfrc_pkg::ST_OK;
    pay_res.decoded_count = '0;
    pay_res.run_last      = !in_data.frame_end;

    st_res.result_kind   = cfrc_pkg::KIND_STATUS;
    st_res.payload_byte  = '0;
    st_res.check_status  = status;
    st_res.decoded_count = count_nxt;
    st_res.run_last      = 1'b1;

    push.num    = 2'd0;
    push.first  = pay_res;
    push.second = st_res;
    if (in_fire) begin
      if (is_pay && in_data.frame_end) begin
        push.num = 2'd2;
      end else if (is_pay) begin
        push.num = 2'd1;
      end else if (in_data.frame_end) begin
        push.num   = 2'd1;
        push.first = st_res;
      end
    end
  end

  // frame state registers; frame_end returns them to reset values
  always_ff @(posedge clk) begin
    if (!rst_n || (in_fire && in_data.frame_end)) begin
      crc_r        <= cfrc_pkg::CRC_ONES;
      pos_r        <= '0;
      magic_ok_r   <= 1'b1;
      version_ok_r <= 1'b1;
      count_r      <= '0;
      for (int i = 0; i < 4; i++) begin
        win_r[i] <= '0;
      end
    end else if (in_fire) begin
      crc_r        <= crc_nxt;
      pos_r        <= pos_nxt;
      magic_ok_r   <= magic_ok_nxt;
      version_ok_r <= version_ok_nxt;
      count_r      <= count_nxt;
      for (int i = 0; i < 4; i++) begin
        win_r[i] <= win_nxt[i];
      end
    end
  end

  // result queue toward the receiver
  cfrc_result_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== verif/tb_crc_framed_record_checker.sv =====
// Testbench for crc_framed_record_checker: random and directed record frames,
// an in-bench frame predictor and a scoreboard. Needs cfrc_pkg and the RTL only.
`timescale 1ns / 1ps

module tb_crc_framed_record_checker;

  // Frame predictor and store of expected results
  class frame_check_sb_t;
    logic [31:0]        crc_reg;
    logic [7:0]         window [4];
    logic [3:0]         pos;
    logic               magic_match;
    logic               version_match;
    logic [31:0]        count_reg;
    logic [31:0]        magic_cfg;
    logic [7:0]         version_cfg;
    cfrc_pkg::out_req_t expected_q [$];
    int                 errors;

    function new();
      magic_cfg   = '0;
      version_cfg = '0;
      errors      = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      crc_reg       = cfrc_pkg::CRC_ONES;
      for (int i = 0; i < 4; i++) window[i] = '0;
      pos           = '0;
      magic_match   = 1'b1;
      version_match = 1'b1;
      count_reg     = '0;
    endfunction

    // reflected CRC-32, one byte, bit by bit
    static function logic [31:0] crc_fold(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int i = 0; i < 8; i++) begin
        if (c[0]) c = (c >> 1) ^ cfrc_pkg::CRC_POLY;
        else c = c >> 1;
      end
      return c;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // accepted input request: advance the frame state, queue what it causes
    function void note_request(input cfrc_pkg::in_req_t req);
      logic [7:0]         leaving;
      logic [3:0]         off;
      logic [31:0]        trailer;
      logic [2:0]         st;
      cfrc_pkg::out_req_t made [2];
      int                 n;
      n = 0;
      if (pos >= 4'd4) begin
        leaving = window[0];
        off     = pos - 4'd4;
        crc_reg = crc_fold(crc_reg, leaving);
        if (off < 4'd4) begin
          if (leaving != magic_cfg[8*off +: 8]) magic_match = 1'b0;
        end else if (off == 4'd4) begin
          if (leaving != version_cfg) version_match = 1'b0;
        end else if (off < 4'd9) begin
          count_reg = count_reg | ({24'd0, leaving} << (8 * (off - 4'd5)));
        end else begin
          made[n]              = '0;
          made[n].result_kind  = cfrc_pkg::KIND_PAYLOAD;
          made[n].payload_byte = leaving;
          n++;
        end
      end
      window[0] = window[1];
      window[1] = window[2];
      window[2] = window[3];
      window[3] = req.frame_byte;
      if (pos < cfrc_pkg::POS_MAX) pos = pos + 4'd1;

      if (req.frame_end) begin
        trailer = {window[3], window[2], window[1], window[0]};
        if (pos < cfrc_pkg::MIN_FRAME) st = cfrc_pkg::ST_SHORT;
        else if (trailer != (crc_reg ^ cfrc_pkg::CRC_ONES)) st = cfrc_pkg::ST_CRC_BAD;
        else if (!magic_match) st = cfrc_pkg::ST_MAGIC_BAD;
        else if (!version_match) st = cfrc_pkg::ST_VER_BAD;
        else st = cfrc_pkg::ST_OK;
        made[n]               = '0;
        made[n].result_kind   = cfrc_pkg::KIND_STATUS;
        made[n].check_status  = st;
        made[n].decoded_count = count_reg;
        n++;
        clear_frame();
      end

      for (int i = 0; i < n; i++) begin
        made[i].run_last = (i == n - 1);
        expected_q.push_back(made[i]);
      end
    endfunction

    function void check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    // accepted result: compare with the oldest expectation
    function void check_result(input cfrc_pkg::out_req_t got);
      cfrc_pkg::out_req_t want;
      if (expected_q.size() == 0) begin
        $error("result with nothing expected: 0x%0h", got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      check_field("result_kind",   want.result_kind,   got.result_kind);
      check_field("payload_byte",  want.payload_byte,  got.payload_byte);
      check_field("check_status",  want.check_status,  got.check_status);
      check_field("decoded_count", want.decoded_count, got.decoded_count);
      check_field("run_last",      want.run_last,      got.run_last);
    endfunction
  endclass

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_BURSTY} rx_mode_t;

  localparam int ITEM_TARGET = 1450;
  localparam int PHASES      = 6;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  cfrc_pkg::in_req_t  in_data;
  logic               out_valid;
  logic               out_ready;
  cfrc_pkg::out_req_t out_data;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [2:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  frame_check_sb_t sb = new();

  logic [7:0]  frame_q [$];
  int          burst_left;
  int          items_sent;
  rx_mode_t    rx_mode;
  int          rx_left;
  int          stall_left;

  crc_framed_record_checker u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Monitor: predict on each accepted request, then check accepted results
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_request(in_data);
      if (out_valid && out_ready) sb.check_result(out_data);
    end
  end

  // Receiver: stall pattern switches among open, coin-flip, sparse and bursty modes
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      rx_left    = 0;
      stall_left = 0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        rx_left = $urandom_range(32, 256);
      end
      rx_left--;
      case (rx_mode)
        RX_OPEN: begin
          out_ready <= 1'b1;
        end
        RX_COIN: begin
          out_ready <= 1'($urandom_range(0, 1));
        end
        RX_SPARSE: begin
          out_ready <= ($urandom_range(0, 3) == 0);
        end
        default: begin
          if (stall_left > 0) begin
            stall_left--;
            out_ready <= 1'b0;
          end else if ($urandom_range(0, 15) == 0) begin
            stall_left = $urandom_range(5, 20);
            out_ready <= 1'b0;
          end else begin
            out_ready <= 1'b1;
          end
        end
      endcase
    end
  end

  // Sender: one byte per request, bursts with random gaps in between
  task automatic send_byte(input logic [7:0] b, input logic e);
    cfrc_pkg::in_req_t req;
    int                gap;
    if (burst_left == 0) begin
      case ($urandom_range(0, 9))
        0, 1, 2: gap = 0;
        9:       gap = $urandom_range(10, 20);
        default: gap = $urandom_range(1, 6);
      endcase
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    req.frame_byte = b;
    req.frame_end  = e;
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    items_sent++;
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_q.size(); i++) send_byte(frame_q[i], i == frame_q.size() - 1);
  endtask

  // Wait for every expected result, then for the block to settle
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // APB write: setup cycle, access cycle, then idle
  task automatic reg_write(input logic reg_sel, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (reg_sel == cfrc_pkg::REG_MAGIC) sb.magic_cfg = value;
    else sb.version_cfg = value[7:0];
    @(posedge clk);
  endtask

  // Well-formed frame with a correct trailer over the given header
  function automatic void build_frame(input int unsigned nrec, input logic [31:0] cnt,
                                      input logic [31:0] magic, input logic [7:0] ver);
    logic [31:0] crc;
    frame_q.delete();
    for (int i = 0; i < 4; i++) frame_q.push_back(magic[8*i +: 8]);
    frame_q.push_back(ver);
    for (int i = 0; i < 4; i++) frame_q.push_back(cnt[8*i +: 8]);
    for (int i = 0; i < nrec; i++) frame_q.push_back(8'($urandom_range(0, 255)));
    crc = cfrc_pkg::CRC_ONES;
    for (int i = 0; i < frame_q.size(); i++) crc = frame_check_sb_t::crc_fold(crc, frame_q[i]);
    crc = crc ^ cfrc_pkg::CRC_ONES;
    for (int i = 0; i < 4; i++) frame_q.push_back(crc[8*i +: 8]);
  endfunction

  // Random frame: mostly good, then header faults, CRC faults, short and noise
  task automatic send_random_frame();
    int          kind;
    int unsigned nrec;
    int          len;
    int          idx;
    logic [31:0] cnt;
    logic [31:0] m;
    logic [7:0]  v;
    kind = $urandom_range(0, 99);
    nrec = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 16);
    cnt  = $urandom_range(0, 1) ? nrec : $urandom();
    m    = sb.magic_cfg;
    v    = sb.version_cfg;
    if ((kind >= 68 && kind <= 75) || (kind >= 84 && kind <= 87)) begin
      idx = $urandom_range(0, 3);
      m[8*idx +: 8] = m[8*idx +: 8] ^ 8'($urandom_range(1, 255));
    end
    if (kind >= 76 && kind <= 87) v = v ^ 8'($urandom_range(1, 255));
    build_frame(nrec, cnt, m, v);
    // corrupt one byte anywhere, trailer included
    if ((kind >= 60 && kind <= 67) || kind == 84 || kind == 85) begin
      idx = $urandom_range(0, frame_q.size() - 1);
      frame_q[idx] = frame_q[idx] ^ 8'($urandom_range(1, 255));
    end
    if (kind >= 88 && kind <= 95) begin
      len = $urandom_range(1, 12);
      while (frame_q.size() > len) void'(frame_q.pop_back());
    end
    if (kind >= 96) begin
      frame_q.delete();
      len = $urandom_range(1, 40);
      for (int i = 0; i < len; i++) frame_q.push_back(8'($urandom_range(0, 255)));
    end
    send_frame();
  endtask

  // Main sequence
  initial begin
    logic [31:0] magic_set;
    logic [7:0]  version_set;
    logic [31:0] crc_fix;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    burst_left = 0;
    items_sent = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: one-byte frame, short frame that has gathered part of the count
    frame_q = '{8'h00};
    send_frame();
    frame_q = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                8'hA5, 8'h5A, 8'hFF};
    send_frame();
    drain();

    // Directed: extreme header values, one all-ones record, good trailer
    reg_write(cfrc_pkg::REG_MAGIC, 32'hFFFF_FFFF);
    reg_write(cfrc_pkg::REG_VERSION, 32'h0000_00FF);
    frame_q.delete();
    build_frame(1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
    frame_q[9] = 8'hFF;
    // trailer again over the patched record
    repeat (4) void'(frame_q.pop_back());
    crc_fix = cfrc_pkg::CRC_ONES;
    for (int i = 0; i < frame_q.size(); i++) begin
      crc_fix = frame_check_sb_t::crc_fold(crc_fix, frame_q[i]);
    end
    crc_fix = crc_fix ^ cfrc_pkg::CRC_ONES;
    for (int i = 0; i < 4; i++) frame_q.push_back(crc_fix[8*i +: 8]);
    send_frame();
    drain();

    // Random phases over several register settings
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin magic_set = 32'h0000_0000; version_set = 8'h00; end
        2: begin magic_set = 32'hFFFF_FFFF; version_set = 8'h00; end
        4: begin magic_set = 32'h0000_0000; version_set = 8'hFF; end
        default: begin magic_set = $urandom(); version_set = 8'($urandom_range(0, 255)); end
      endcase
      reg_write(cfrc_pkg::REG_MAGIC, magic_set);
      reg_write(cfrc_pkg::REG_VERSION, {24'd0, version_set});
      while (items_sent < ITEM_TARGET * (p + 1) / PHASES + 27) begin
        send_random_frame();
        // hold off now and then until every result is back
        if ($urandom_range(0, 19) == 0) drain();
      end
      drain();
    end

    repeat (10) @(posedge clk);
    if (sb.pending() != 0) begin
      $error("%0d expected results never arrived", sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
